### rtl/rc6_pkg.sv
`timescale 1ns / 1ps

package rc6_pkg;

  localparam int ROUNDS_DEF = 20;
  localparam int LG_W       = 5;
  localparam int KEY_REGS   = 4;
  localparam int MAX_KEY_B  = 32;
  localparam int L_WORDS    = 8;

  localparam logic [31:0] MAGIC_P = 32'hB7E15163;
  localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 3'd4;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 6'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY_LOAD,
    ST_INIT,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_PRE,
    ST_WIN,
    ST_ROUND,
    ST_WOUT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD_BLOCK,
    DP_KEY_LOAD,
    DP_INIT_WR,
    DP_MIX_RD,
    DP_MIX_WR,
    DP_WHITE_IN,
    DP_ROUND,
    DP_WHITE_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   j_step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic decrypt;
  } dp_status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] sh);
    logic [63:0] w;
    w = {x, x} << sh;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] sh);
    logic [63:0] w;
    w = {x, x} >> sh;
    return w[31:0];
  endfunction

  // quadratic mixing term of a round
  function automatic logic [31:0] mix_f(input logic [31:0] x);
    logic [31:0] p;
    p = x * {x[30:0], 1'b1};
    return rotl32(p, 5'(LG_W));
  endfunction

endpackage

### rtl/rc6_if.sv
`timescale 1ns / 1ps

interface rc6_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] block_a;
  logic [31:0] block_b;
  logic [31:0] block_c;
  logic [31:0] block_d;

  modport source (output valid, cmd, block_a, block_b, block_c, block_d, input ready);
  modport sink (input valid, cmd, block_a, block_b, block_c, block_d, output ready);
endinterface

interface rc6_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_a;
  logic [31:0] out_b;
  logic [31:0] out_c;
  logic [31:0] out_d;

  modport source (output valid, out_a, out_b, out_c, out_d, input ready);
  modport sink (input valid, out_a, out_b, out_c, out_d, output ready);
endinterface

### rtl/rc6_ram.sv
`timescale 1ns / 1ps

module rc6_ram #(
  parameter int Width = 32,
  parameter int Depth = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr0,
  input  logic [$clog2(Depth)-1:0] raddr1,
  output logic [Width-1:0]         rdata0,
  output logic [Width-1:0]         rdata1
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

### rtl/rc6_datapath.sv
`timescale 1ns / 1ps

module rc6_datapath import rc6_pkg::*; #(
  parameter int KeyWords = 2 * ROUNDS_DEF + 4,
  parameter int AddrW    = $clog2(2 * ROUNDS_DEF + 4)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_cmd,
  input  logic [31:0]           in_a,
  input  logic [31:0]           in_b,
  input  logic [31:0]           in_c,
  input  logic [31:0]           in_d,
  input  dp_cmd_t               cmd,
  input  logic [AddrW-1:0]      idx,
  input  logic [AddrW-1:0]      pair,
  output dp_status_t            status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_a,
  output logic [31:0]           out_b,
  output logic [31:0]           out_c,
  output logic [31:0]           out_d
);

  logic [CFG_DATA_W-1:0] key_r [KEY_REGS];
  logic [KEY_LEN_W-1:0]  key_len_r;
  logic [31:0]           l_r [L_WORDS];
  logic [31:0]           ka_r, kb_r, sum_r;
  logic [2:0]            j_r, c_last_r;
  logic                  dec_r;
  logic [31:0]           a_r, b_r, c_r, d_r;
  logic [31:0]           oa_r, ob_r, oc_r, od_r;
  logic                  out_valid_r;

  logic                  ram_we;
  logic [AddrW-1:0]      raddr0, raddr1;
  logic [31:0]           wdata, rk0, rk1;

  logic [KEY_LEN_W-1:0]  blen;
  logic [3:0]            cwords;
  logic [31:0]           l_load [L_WORDS];
  logic [31:0]           mix_a, mix_bs, mix_l;
  logic [31:0]           t, u;

  // ---- key length and key word packing ----
  always_comb begin
    blen   = (key_len_r > KEY_LEN_W'(MAX_KEY_B)) ? KEY_LEN_W'(MAX_KEY_B) : key_len_r;
    cwords = 4'((7'(blen) + 7'd3) >> 2);
    if (cwords == 4'd0) begin
      cwords = 4'd1;
    end
    for (int w = 0; w < L_WORDS; w++) begin
      for (int m = 0; m < 4; m++) begin
        if ((4 * w + m) < int'(blen)) begin
          l_load[w][8*m +: 8] = key_r[(4 * w + m) / 8][8 * ((4 * w + m) % 8) +: 8];
        end else begin
          l_load[w][8*m +: 8] = 8'h00;
        end
      end
    end
  end

  // ---- one mixing step of the schedule ----
  always_comb begin
    mix_a  = rotl32(rk0 + ka_r + kb_r, 5'd3);
    mix_bs = mix_a + kb_r;
    mix_l  = rotl32(l_r[j_r] + mix_bs, mix_bs[4:0]);
  end

  // ---- round key store ----
  always_comb begin
    ram_we = (cmd.op == DP_INIT_WR) || (cmd.op == DP_MIX_WR);
    wdata  = (cmd.op == DP_INIT_WR) ? sum_r : mix_a;
    if (cmd.op == DP_MIX_RD) begin
      raddr0 = idx;
      raddr1 = idx;
    end else begin
      raddr0 = {pair[AddrW-2:0], 1'b0};
      raddr1 = {pair[AddrW-2:0], 1'b1};
    end
  end

  rc6_ram #(
    .Width(32),
    .Depth(KeyWords)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (wdata),
    .raddr0(raddr0),
    .raddr1(raddr1),
    .rdata0(rk0),
    .rdata1(rk1)
  );

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < KEY_REGS; r++) begin
        key_r[r] <= '0;
      end
      key_len_r <= KEY_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY0:    key_r[0] <= cfg_data;
        CFG_KEY1:    key_r[1] <= cfg_data;
        CFG_KEY2:    key_r[2] <= cfg_data;
        CFG_KEY3:    key_r[3] <= cfg_data;
        CFG_KEY_LEN: key_len_r <= cfg_data[KEY_LEN_W-1:0];
        default:     ;
      endcase
    end
  end

  // ---- schedule working state ----
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_KEY_LOAD: begin
        for (int w = 0; w < L_WORDS; w++) begin
          l_r[w] <= l_load[w];
        end
        ka_r     <= '0;
        kb_r     <= '0;
        j_r      <= '0;
        c_last_r <= 3'(cwords - 4'd1);
        sum_r    <= MAGIC_P;
      end
      DP_INIT_WR: sum_r <= sum_r + MAGIC_Q;
      DP_MIX_WR: begin
        ka_r     <= mix_a;
        kb_r     <= mix_l;
        l_r[j_r] <= mix_l;
        if (cmd.j_step) begin
          j_r <= (j_r == c_last_r) ? 3'd0 : j_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  // ---- cipher rounds ----
  always_comb begin
    if (dec_r) begin
      t = mix_f(a_r);
      u = mix_f(c_r);
    end else begin
      t = mix_f(b_r);
      u = mix_f(d_r);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD_BLOCK: begin
        dec_r <= in_cmd;
        a_r   <= in_a;
        b_r   <= in_b;
        c_r   <= in_c;
        d_r   <= in_d;
      end
      DP_WHITE_IN: begin
        if (dec_r) begin
          a_r <= a_r - rk0;
          c_r <= c_r - rk1;
        end else begin
          b_r <= b_r + rk0;
          d_r <= d_r + rk1;
        end
      end
      DP_ROUND: begin
        if (dec_r) begin
          a_r <= rotr32(d_r - rk0, u[4:0]) ^ t;
          b_r <= a_r;
          c_r <= rotr32(b_r - rk1, t[4:0]) ^ u;
          d_r <= c_r;
        end else begin
          a_r <= b_r;
          b_r <= rotl32(c_r ^ u, t[4:0]) + rk1;
          c_r <= d_r;
          d_r <= rotl32(a_r ^ t, u[4:0]) + rk0;
        end
      end
      default: ;
    endcase
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (cmd.op == DP_WHITE_OUT) begin
      if (dec_r) begin
        oa_r <= a_r;
        ob_r <= b_r - rk0;
        oc_r <= c_r;
        od_r <= d_r - rk1;
      end else begin
        oa_r <= a_r + rk0;
        ob_r <= b_r;
        oc_r <= c_r + rk1;
        od_r <= d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_WHITE_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_busy = out_valid_r & ~out_ready;
  assign status.decrypt  = dec_r;
  assign out_valid       = out_valid_r;
  assign out_a           = oa_r;
  assign out_b           = ob_r;
  assign out_c           = oc_r;
  assign out_d           = od_r;

endmodule

### rtl/rc6_ctrl.sv
`timescale 1ns / 1ps

module rc6_ctrl import rc6_pkg::*; #(
  parameter int Rounds   = ROUNDS_DEF,
  parameter int KeyWords = 2 * ROUNDS_DEF + 4,
  parameter int AddrW    = $clog2(2 * ROUNDS_DEF + 4)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dp_status_t           status,
  output dp_cmd_t              cmd,
  output logic [AddrW-1:0]     idx,
  output logic [AddrW-1:0]     pair,
  output logic                 sched_ready
);

  localparam int StepW = $clog2(3 * KeyWords);
  localparam int RndW  = $clog2(Rounds + 1);

  state_t           state_r, state_nxt;
  logic [AddrW-1:0] idx_r, idx_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [RndW-1:0]  rnd_r, rnd_nxt;
  logic             sched_r, sched_nxt;
  logic             idx_last, step_last, rnd_last;

  assign idx_last  = (idx_r == AddrW'(KeyWords - 1));
  assign step_last = (step_r == StepW'(3 * KeyWords - 1));
  assign rnd_last  = (rnd_r == RndW'(Rounds));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    rnd_nxt   = rnd_r;
    sched_nxt = sched_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sched_r ? ST_PRE : ST_KEY_LOAD;
        end
      end
      ST_KEY_LOAD: begin
        idx_nxt   = '0;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        if (idx_last) begin
          idx_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_MIX_RD;
        end else begin
          idx_nxt = idx_r + AddrW'(1);
        end
      end
      ST_MIX_RD: state_nxt = ST_MIX_WR;
      ST_MIX_WR: begin
        idx_nxt  = idx_last ? '0 : idx_r + AddrW'(1);
        step_nxt = step_r + StepW'(1);
        if (step_last) begin
          sched_nxt = 1'b1;
          state_nxt = ST_PRE;
        end else begin
          state_nxt = ST_MIX_RD;
        end
      end
      ST_PRE: state_nxt = ST_WIN;
      ST_WIN: begin
        rnd_nxt   = RndW'(1);
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + RndW'(1);
        if (rnd_last) begin
          state_nxt = ST_WOUT;
        end
      end
      ST_WOUT: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we && (cfg_index <= CFG_KEY_LEN)) begin
      sched_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd.op     = DP_NOP;
    cmd.j_step = 1'b0;
    in_ready   = 1'b0;
    pair       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? DP_LOAD_BLOCK : DP_NOP;
      end
      ST_KEY_LOAD: cmd.op = DP_KEY_LOAD;
      ST_INIT:     cmd.op = DP_INIT_WR;
      ST_MIX_RD:   cmd.op = DP_MIX_RD;
      ST_MIX_WR: begin
        cmd.op     = DP_MIX_WR;
        cmd.j_step = 1'b1;
      end
      ST_PRE: begin
        pair = status.decrypt ? AddrW'(Rounds + 1) : '0;
      end
      ST_WIN: begin
        cmd.op = DP_WHITE_IN;
        pair   = status.decrypt ? AddrW'(Rounds) : AddrW'(1);
      end
      ST_ROUND: begin
        cmd.op = DP_ROUND;
        pair   = status.decrypt ? AddrW'(Rounds) - AddrW'(rnd_r) : AddrW'(rnd_r) + AddrW'(1);
      end
      ST_WOUT: begin
        cmd.op = status.out_busy ? DP_NOP : DP_WHITE_OUT;
        pair   = status.decrypt ? '0 : AddrW'(Rounds + 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sched_r <= 1'b0;
      idx_r   <= '0;
      step_r  <= '0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sched_r <= sched_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  assign idx         = idx_r;
  assign sched_ready = sched_r;

endmodule

### rtl/rc6_block_cipher.sv
`timescale 1ns / 1ps

// channel  | dir | beat contents
// in_ch    | in  | cmd (0 encrypt, 1 decrypt), block_a..block_d
// out_ch   | out | out_a..out_d
// cfg      | in  | cfg_we, cfg_index (0-3 key words of 8 bytes, 4 key length), cfg_data
//
// a block goes from accept through key prefetch, input whitening, the rounds and output whitening:
// one round per cycle, paced by the two-read-port round key memory
// after a key change the first block also pays the schedule: a key load, a fill
// of all KeyWords table words, then 3 * KeyWords mix steps, each a read then a write
// reset is synchronous, active low; the schedule is marked stale
// a new beat is taken while the last result waits in the output register;
// the datapath holds in the final whitening step until that register frees

module rc6_block_cipher import rc6_pkg::*; #(
  parameter int Rounds = ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rc6_in_if.sink                in_ch,
  rc6_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int KeyWords = 2 * Rounds + 4;
  localparam int AddrW    = $clog2(KeyWords);

  dp_cmd_t          dp_cmd;
  dp_status_t       dp_status;
  logic [AddrW-1:0] key_idx, key_pair;
  logic             sched_ready;

  // sequencer: key schedule and round stepping
  rc6_ctrl #(
    .Rounds  (Rounds),
    .KeyWords(KeyWords),
    .AddrW   (AddrW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .status     (dp_status),
    .cmd        (dp_cmd),
    .idx        (key_idx),
    .pair       (key_pair),
    .sched_ready(sched_ready)
  );

  // key registers, round key memory, block words and result register
  rc6_datapath #(
    .KeyWords(KeyWords),
    .AddrW   (AddrW)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_cmd   (in_ch.cmd),
    .in_a     (in_ch.block_a),
    .in_b     (in_ch.block_b),
    .in_c     (in_ch.block_c),
    .in_d     (in_ch.block_d),
    .cmd      (dp_cmd),
    .idx      (key_idx),
    .pair     (key_pair),
    .status   (dp_status),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_a    (out_ch.out_a),
    .out_b    (out_ch.out_b),
    .out_c    (out_ch.out_c),
    .out_d    (out_ch.out_d)
  );

`ifndef NO_ASSERTIONS
  // one block in flight: no accept right after an accept
  a_one_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a block is in flight");

  // a key write marks the schedule stale
  a_key_stale: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index <= CFG_KEY_LEN) |=> !sched_ready)
    else $error("schedule still marked ready after key write");

  // no datapath work while waiting for a beat
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (dp_cmd.op == DP_NOP || dp_cmd.op == DP_LOAD_BLOCK))
    else $error("datapath busy while ready for input");

  // the result register is never overwritten while it waits
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.op == DP_WHITE_OUT |-> !(out_ch.valid && !out_ch.ready))
    else $error("result overwritten before being taken");
`endif

endmodule

### test/rc6_tb_if.sv
`timescale 1ns / 1ps

// the interfaces come with the rtl (rtl/rc6_if.sv); this file only holds the
// plain beat type the bench passes between its tasks and its scoreboard

package rc6_tb_pkg;

  typedef struct {
    logic        cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } rc6_beat_t;

endpackage

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rc6_pkg::*;
  import rc6_tb_pkg::*;

  localparam int NR = ROUNDS_DEF;
  localparam int NKEY = 2 * NR + 4;
  localparam bit CMD_ENC = 1'b0;
  localparam bit CMD_DEC = 1'b1;

  // cipher predictor with its own key registers and schedule
  class rc6_scoreboard;
    logic [63:0] key_q [4];
    logic [5:0]  key_len;
    logic [31:0] sched [NKEY];
    bit          sched_ok;
    rc6_beat_t   expected_q [$];
    int          mismatches;
    int          checked;
    int          n_enc, n_dec;

    function void clear();
      foreach (key_q[i]) key_q[i] = '0;
      key_len = KEY_LEN_RST;
      sched_ok = 0;
      expected_q.delete();
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      if (idx <= CFG_KEY3) begin
        key_q[idx] = val;
        sched_ok = 0;
      end else if (idx == CFG_KEY_LEN) begin
        key_len = val[5:0];
        sched_ok = 0;
      end
    endfunction

    function logic [31:0] rol(logic [31:0] x, logic [31:0] n);
      logic [4:0] s;
      s = n[4:0];
      return (s == 0) ? x : ((x << s) | (x >> (6'd32 - s)));
    endfunction

    function logic [31:0] ror(logic [31:0] x, logic [31:0] n);
      logic [4:0] s;
      s = n[4:0];
      return (s == 0) ? x : ((x >> s) | (x << (6'd32 - s)));
    endfunction

    function logic [31:0] quad(logic [31:0] x);
      logic [31:0] p;
      p = x * (2 * x + 1);
      return rol(p, 5);
    endfunction

    function void build_schedule();
      logic [31:0] lw [8];
      int nb, nc, steps, i, j;
      logic [31:0] ra, rb;
      logic [7:0] kb;
      nb = (key_len > 32) ? 32 : key_len;
      nc = (nb + 3) / 4;
      if (nc == 0) nc = 1;
      foreach (lw[k]) lw[k] = '0;
      for (int k = nb - 1; k >= 0; k--) begin
        kb = key_q[k >> 3][(k & 7) * 8 +: 8];
        lw[k >> 2] = (lw[k >> 2] << 8) + kb;
      end
      sched[0] = MAGIC_P;
      for (int k = 1; k < NKEY; k++) sched[k] = sched[k-1] + MAGIC_Q;
      steps = 3 * ((nc > NKEY) ? nc : NKEY);
      ra = 0; rb = 0; i = 0; j = 0;
      for (int s = 0; s < steps; s++) begin
        ra = rol(sched[i] + ra + rb, 3);
        sched[i] = ra;
        rb = rol(lw[j] + ra + rb, ra + rb);
        lw[j] = rb;
        i = (i + 1) % NKEY;
        j = (j + 1) % nc;
      end
      sched_ok = 1;
    endfunction

    // note an accepted input beat: compute its ciphertext or plaintext
    function void note_input(rc6_beat_t x);
      logic [31:0] a, b, c, d, t, u, w;
      rc6_beat_t r;
      if (!sched_ok) build_schedule();
      a = x.a; b = x.b; c = x.c; d = x.d;
      if (x.cmd == CMD_ENC) begin
        n_enc++;
        b += sched[0];
        d += sched[1];
        for (int i = 1; i <= NR; i++) begin
          t = quad(b);
          u = quad(d);
          a = rol(a ^ t, u) + sched[2*i];
          c = rol(c ^ u, t) + sched[2*i+1];
          w = a; a = b; b = c; c = d; d = w;
        end
        a += sched[2*NR+2];
        c += sched[2*NR+3];
      end else begin
        n_dec++;
        c -= sched[2*NR+3];
        a -= sched[2*NR+2];
        for (int i = NR; i >= 1; i--) begin
          w = d; d = c; c = b; b = a; a = w;
          u = quad(d);
          t = quad(b);
          c = ror(c - sched[2*i+1], t) ^ u;
          a = ror(a - sched[2*i], u) ^ t;
        end
        d -= sched[1];
        b -= sched[0];
      end
      r.cmd = x.cmd;
      r.a = a; r.b = b; r.c = c; r.d = d;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                               logic [31:0] d);
      rc6_beat_t e;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h %h %h %h", a, b, c, d);
        return;
      end
      e = expected_q.pop_front();
      if (a !== e.a || b !== e.b || c !== e.c || d !== e.d) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch (%s): exp %h %h %h %h got %h %h %h %h",
                   e.cmd ? "dec" : "enc", e.a, e.b, e.c, e.d, a, b, c, d);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  rc6_in_if  in_ch ();
  rc6_out_if out_ch ();

  rc6_block_cipher u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  rc6_scoreboard sb;
  int  hold_off = 0;  // long receiver stall, counted in cycles
  bit  stall_mode = 0;
  int  key_sets = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.block_a = '0;
    in_ch.block_b = '0;
    in_ch.block_c = '0;
    in_ch.block_d = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_mode) begin
      out_ch.ready <= ($urandom_range(0, 3) == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.out_a, out_ch.out_b, out_ch.out_c, out_ch.out_d);
  end

  // drive one beat and wait for its accept; valid stays up across back-to-back beats
  task automatic send_beat(logic cmd, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d);
    rc6_beat_t x;
    x.cmd = cmd; x.a = a; x.b = b; x.c = c; x.d = d;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.block_a <= a;
    in_ch.block_b <= b;
    in_ch.block_c <= c;
    in_ch.block_d <= d;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(x);
  endtask

  // a zero gap keeps valid up for the next beat
  task automatic go_idle(int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && count > 0; k++, count--)
        send_beat($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
      go_idle($urandom_range(0, 1) ? 0 : $urandom_range(1, 30));
    end
    go_idle(0);
  endtask

  // wait for every result, then a short idle stretch
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (NR + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3, logic [5:0] len);
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_KEY_LEN, {58'd0, len});
    cfg_we <= 1'b0;
    key_sets++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    rc6_beat_t pt;
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key: all-zero 16 bytes, with field extremes and both commands
    send_beat(CMD_ENC, '0, '0, '0, '0);
    send_beat(CMD_DEC, '0, '0, '0, '0);
    send_beat(CMD_ENC, '1, '1, '1, '1);
    send_beat(CMD_DEC, '1, '1, '1, '1);
    send_beat(CMD_ENC, 32'h8000_0001, 32'h0000_0001, 32'h7FFF_FFFF, 32'hAAAA_5555);
    send_beat(CMD_DEC, 32'h5555_AAAA, 32'h8000_0000, 32'h0000_0002, 32'hFFFF_FFFE);
    drain();

    // key length extremes: one byte, all ones full length, zero length
    load_key('1, '0, '0, '0, 6'd1);
    send_beat(CMD_ENC, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    send_beat(CMD_DEC, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    drain();
    load_key('1, '1, '1, '1, 6'd32);
    send_beat(CMD_ENC, '1, '0, '1, '0);
    send_beat(CMD_DEC, '0, '1, '0, '1);
    drain();
    load_key(rand64(), rand64(), rand64(), rand64(), 6'd0);
    send_beat(CMD_ENC, $urandom, $urandom, $urandom, $urandom);
    drain();
    // length above 32 saturates; 63 sets all length bits
    load_key(rand64(), rand64(), rand64(), rand64(), 6'd63);
    send_beat(CMD_DEC, $urandom, $urandom, $urandom, $urandom);
    send_beat(CMD_ENC, $urandom, $urandom, $urandom, $urandom);
    drain();

    // random keys and lengths, receiver stalling now and then
    stall_mode = 1;
    for (int ph = 0; ph < 12; ph++) begin
      load_key(rand64(), rand64(), rand64(), rand64(),
               (ph % 4 == 0) ? 6'd32 : 6'($urandom_range(0, 40)));
      stall_mode = ph[0];
      send_random(90);
      drain();
    end

    // encrypt then decrypt of the same block: the block is pushed through
    // both ways, the scoreboard predicts both
    for (int k = 0; k < 40; k++) begin
      pt.a = $urandom; pt.b = $urandom; pt.c = $urandom; pt.d = $urandom;
      send_beat(CMD_ENC, pt.a, pt.b, pt.c, pt.d);
      send_beat(CMD_DEC, pt.a, pt.b, pt.c, pt.d);
    end
    go_idle(0);

    // long receiver hold-off while the sender keeps offering beats
    hold_off = 400;
    send_random(60);
    // pause until every result is back, then go on
    drain();
    stall_mode = 1;
    send_random(150);
    drain();

    $display("covered %0d encrypt and %0d decrypt blocks over %0d key settings",
             sb.n_enc, sb.n_dec, key_sets);
    $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
